>>> sv/tmr_pkg.sv
package tmr_pkg;

   // Field widths fixed by the item layout
   localparam int CELL_W  = 10;
   localparam int STATE_W = 6;
   localparam int SYM_W   = 2;
   localparam int STEP_W  = 20;
   localparam int STAT_W  = 3;

   typedef logic signed [CELL_W-1:0] cell_type;
   typedef logic [STATE_W-1:0]       mstate_type;
   typedef logic [SYM_W-1:0]         sym_type;
   typedef logic [STEP_W-1:0]        step_type;
   typedef logic [STAT_W-1:0]        status_type;

   // Item kinds
   localparam logic [1:0] KIND_FILL = 2'd0;
   localparam logic [1:0] KIND_LOAD = 2'd1;
   localparam logic [1:0] KIND_RUN  = 2'd2;
   localparam logic [1:0] KIND_READ = 2'd3;

   // Tape symbols
   localparam sym_type SYM_BLANK = 2'd0;
   localparam sym_type SYM_ZERO  = 2'd1;
   localparam sym_type SYM_ONE   = 2'd2;

   // Rule halt codes
   localparam logic [1:0] HALT_NONE   = 2'd0;
   localparam logic [1:0] HALT_ACCEPT = 2'd1;
   localparam logic [1:0] HALT_REJECT = 2'd2;

   // Move codes
   localparam logic MOVE_LEFT  = 1'b0;
   localparam logic MOVE_RIGHT = 1'b1;

   // Result status codes
   localparam status_type STATUS_DONE     = 3'd0;
   localparam status_type STATUS_ACCEPTED = 3'd1;
   localparam status_type STATUS_REJECTED = 3'd2;
   localparam status_type STATUS_NO_RULE  = 3'd3;
   localparam status_type STATUS_OFF_TAPE = 3'd4;
   localparam status_type STATUS_LIMIT    = 3'd5;
   localparam status_type STATUS_BAD      = 3'd6;

   // Step limit after reset
   localparam step_type LIMIT_RESET = 20'hFFFFF;

   // Payload of one stored rule
   typedef struct packed {
      logic [1:0] halt;
      mstate_type next;
      sym_type    wr_sym;
      logic       move;
   } rule_type;

endpackage

>>> sv/tmr_req_if.sv
interface tmr_req_if;
   logic                 valid;
   logic                 ready;
   logic [1:0]           kind;
   tmr_pkg::cell_type    first_cell;
   tmr_pkg::cell_type    last_cell;
   tmr_pkg::sym_type     fill_symbol;
   tmr_pkg::mstate_type  rule_state;
   tmr_pkg::sym_type     rule_read;
   logic [1:0]           rule_halt;
   tmr_pkg::mstate_type  rule_next;
   tmr_pkg::sym_type     rule_write;
   logic                 rule_move;

   modport source (
      output valid, kind, first_cell, last_cell, fill_symbol, rule_state, rule_read,
             rule_halt, rule_next, rule_write, rule_move,
      input  ready
   );

   modport sink (
      input  valid, kind, first_cell, last_cell, fill_symbol, rule_state, rule_read,
             rule_halt, rule_next, rule_write, rule_move,
      output ready
   );
endinterface

>>> sv/tmr_rsp_if.sv
interface tmr_rsp_if;
   logic                 valid;
   logic                 ready;
   tmr_pkg::status_type  status;
   tmr_pkg::sym_type     cell_symbol;
   tmr_pkg::cell_type    head_cell;
   tmr_pkg::step_type    steps_taken;

   modport source (
      output valid, status, cell_symbol, head_cell, steps_taken,
      input  ready
   );

   modport sink (
      input  valid, status, cell_symbol, head_cell, steps_taken,
      output ready
   );
endinterface

>>> sv/turing_machine_runner.sv
// Three-symbol single-tape Turing machine.
// req_ch (valid/ready) takes one item: fill a cell range, load a rule, run
// from a cell in machine state 0, or read a cell. rsp_ch returns exactly one
// item per request with status, cell symbol, head cell and step count.
// csr_wr_en/csr_wr_data write the step limit; write it only while idle.
// A load goes straight to the done state, a read passes a peek and a capture
// state, a fill writes its cells in turn, and a run repeats transitions. Each
// transition is a tape read, a rule lookup and a write-back through the one
// index step unit, in three sequencer steps. One item is in work at a time.
// After reset the tape is swept to blank while req_ch.ready stays low; rules
// reset to unloaded and the limit to 1048575.
// The result sits in an output register, so the next item is taken while a
// result waits; if the receiver stalls, a finished item holds in a staging
// register and no further item is taken until the output register frees.
module turing_machine_runner #(
   parameter int TAPE_CELLS     = 1024,
   parameter int MACHINE_STATES = 64
) (
   input  logic              clock,
   input  logic              reset,
   tmr_req_if.sink           req_ch,
   tmr_rsp_if.source         rsp_ch,
   input  logic              csr_wr_en,
   input  tmr_pkg::step_type csr_wr_data
);

   localparam int IW          = $clog2(TAPE_CELLS);
   localparam int AW          = ((IW > tmr_pkg::CELL_W) ? IW : tmr_pkg::CELL_W) + 2;
   localparam int USED_STATES = (MACHINE_STATES < 64) ? MACHINE_STATES : 64;
   localparam int SLOTS       = USED_STATES * 3;
   localparam int SW          = $clog2(SLOTS);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_FILL     = 3'd1;
   localparam logic [2:0] S_PEEK     = 3'd2;
   localparam logic [2:0] S_PEEK_CAP = 3'd3;
   localparam logic [2:0] S_RUN_RD   = 3'd4;
   localparam logic [2:0] S_RUN_LK   = 3'd5;
   localparam logic [2:0] S_RUN_EX   = 3'd6;
   localparam logic [2:0] S_DONE     = 3'd7;

   logic [2:0]            state_ff, state_in;
   logic [IW-1:0]         cur_idx_ff, cur_idx_in;
   logic [IW-1:0]         last_idx_ff, last_idx_in;
   tmr_pkg::sym_type      fill_sym_ff, fill_sym_in;
   tmr_pkg::mstate_type   mstate_ff, mstate_in;
   tmr_pkg::step_type     steps_ff, steps_in;
   tmr_pkg::sym_type      sym_ff, sym_in;
   tmr_pkg::step_type     limit_ff, limit_in;

   tmr_pkg::status_type   res_status_ff, res_status_in;
   tmr_pkg::sym_type      res_sym_ff, res_sym_in;
   tmr_pkg::cell_type     res_head_ff, res_head_in;
   tmr_pkg::step_type     res_steps_ff, res_steps_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   tmr_pkg::status_type   rsp_status_ff, rsp_status_in;
   tmr_pkg::sym_type      rsp_sym_ff, rsp_sym_in;
   tmr_pkg::cell_type     rsp_head_ff, rsp_head_in;
   tmr_pkg::step_type     rsp_steps_ff, rsp_steps_in;

   logic                  tape_clearing;
   logic                  tape_we;
   tmr_pkg::sym_type      tape_wd;
   tmr_pkg::sym_type      tape_rd;

   logic                  rule_we;
   logic [SW-1:0]         rule_wr_slot;
   tmr_pkg::rule_type     rule_wr;
   logic [SW-1:0]         rule_rd_slot;
   tmr_pkg::rule_type     rule_rd;
   logic                  rule_rd_valid;
   logic [8:0]            wr_slot_w;
   logic [8:0]            rd_slot_w;

   logic                  accept;
   logic                  out_free;
   logic signed [AW-1:0]  first_wide, last_wide;
   logic                  first_ok, last_ok;
   logic                  load_bad;

   logic                  unit_up;
   logic [IW-1:0]         unit_next;
   logic                  unit_edge;
   logic signed [AW-1:0]  cur_head_w, next_head_w;
   tmr_pkg::step_type     steps_inc;

   // Tape and rule storage
   tmr_tape #(.TAPE_CELLS(TAPE_CELLS)) u_tape (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (tape_we),
      .wr_addr  (cur_idx_ff),
      .wr_data  (tape_wd),
      .rd_addr  (cur_idx_ff),
      .rd_data  (tape_rd),
      .clearing (tape_clearing)
   );

   tmr_rules #(.SLOTS(SLOTS)) u_rules (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (rule_we),
      .wr_slot  (rule_wr_slot),
      .wr_rule  (rule_wr),
      .rd_slot  (rule_rd_slot),
      .rd_rule  (rule_rd),
      .rd_valid (rule_rd_valid)
   );

   // Handshakes
   assign req_ch.ready = (state_ff == S_IDLE) && !tape_clearing;
   assign accept       = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   // Cell to tape index, with range checks
   assign first_wide = AW'(req_ch.first_cell) + AW'(TAPE_CELLS / 2);
   assign last_wide  = AW'(req_ch.last_cell) + AW'(TAPE_CELLS / 2);
   assign first_ok   = !first_wide[AW-1] && (first_wide < AW'(TAPE_CELLS));
   assign last_ok    = !last_wide[AW-1] && (last_wide < AW'(TAPE_CELLS));

   // Rule slot = state * 3 + symbol
   assign wr_slot_w    = {2'b0, req_ch.rule_state, 1'b0} + {3'b0, req_ch.rule_state}
                       + {7'b0, req_ch.rule_read};
   assign rd_slot_w    = {2'b0, mstate_ff, 1'b0} + {3'b0, mstate_ff} + {7'b0, tape_rd};
   assign rule_wr_slot = wr_slot_w[SW-1:0];
   assign rule_rd_slot = rd_slot_w[SW-1:0];
   assign rule_wr      = '{halt:   req_ch.rule_halt,
                           next:   req_ch.rule_next,
                           wr_sym: req_ch.rule_write,
                           move:   req_ch.rule_move};

   assign load_bad = (req_ch.rule_read > tmr_pkg::SYM_ONE)
                  || (req_ch.rule_write > tmr_pkg::SYM_ONE)
                  || (req_ch.rule_halt > tmr_pkg::HALT_REJECT)
                  || ({26'b0, req_ch.rule_state} >= 32'(MACHINE_STATES))
                  || ((req_ch.rule_halt == tmr_pkg::HALT_NONE)
                      && ({26'b0, req_ch.rule_next} >= 32'(MACHINE_STATES)));
   assign rule_we  = accept && (req_ch.kind == tmr_pkg::KIND_LOAD) && !load_bad;

   // Shared index step unit: move one cell and flag the tape edge
   assign unit_up   = (state_ff == S_FILL) || (rule_rd.move == tmr_pkg::MOVE_RIGHT);
   assign unit_next = unit_up ? cur_idx_ff + IW'(1) : cur_idx_ff - IW'(1);
   assign unit_edge = unit_up ? (cur_idx_ff == IW'(TAPE_CELLS - 1)) : (cur_idx_ff == '0);

   assign cur_head_w  = $signed(AW'(cur_idx_ff)) - AW'(TAPE_CELLS / 2);
   assign next_head_w = $signed(AW'(unit_next)) - AW'(TAPE_CELLS / 2);
   assign steps_inc   = steps_ff + tmr_pkg::STEP_W'(1);

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      cur_idx_in    = cur_idx_ff;
      last_idx_in   = last_idx_ff;
      fill_sym_in   = fill_sym_ff;
      mstate_in     = mstate_ff;
      steps_in      = steps_ff;
      sym_in        = sym_ff;
      res_status_in = res_status_ff;
      res_sym_in    = res_sym_ff;
      res_head_in   = res_head_ff;
      res_steps_in  = res_steps_ff;
      tape_we       = 1'b0;
      tape_wd       = fill_sym_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_status_in = tmr_pkg::STATUS_BAD;
               res_sym_in    = tmr_pkg::SYM_BLANK;
               res_head_in   = '0;
               res_steps_in  = '0;
               state_in      = S_DONE;
               case (req_ch.kind)
                  tmr_pkg::KIND_FILL: begin
                     if (req_ch.fill_symbol > tmr_pkg::SYM_ONE) begin
                        res_status_in = tmr_pkg::STATUS_BAD;
                     end else if (req_ch.last_cell < req_ch.first_cell) begin
                        res_status_in = tmr_pkg::STATUS_DONE;
                     end else if (first_ok && last_ok) begin
                        res_status_in = tmr_pkg::STATUS_DONE;
                        cur_idx_in    = first_wide[IW-1:0];
                        last_idx_in   = last_wide[IW-1:0];
                        fill_sym_in   = req_ch.fill_symbol;
                        state_in      = S_FILL;
                     end
                  end
                  tmr_pkg::KIND_LOAD: begin
                     if (!load_bad) begin
                        res_status_in = tmr_pkg::STATUS_DONE;
                     end
                  end
                  tmr_pkg::KIND_READ: begin
                     if (first_ok) begin
                        res_status_in = tmr_pkg::STATUS_DONE;
                        cur_idx_in    = first_wide[IW-1:0];
                        state_in      = S_PEEK;
                     end
                  end
                  tmr_pkg::KIND_RUN: begin
                     if (first_ok) begin
                        cur_idx_in = first_wide[IW-1:0];
                        mstate_in  = '0;
                        steps_in   = '0;
                        state_in   = S_RUN_RD;
                     end
                  end
                  default: begin
                     res_status_in = tmr_pkg::STATUS_BAD;
                  end
               endcase
            end
         end

         // Write one cell a cycle up to the range end
         S_FILL: begin
            tape_we = 1'b1;
            tape_wd = fill_sym_ff;
            if (cur_idx_ff == last_idx_ff) begin
               state_in = S_DONE;
            end else begin
               cur_idx_in = unit_next;
            end
         end

         // Read the cell under the index, then capture it
         S_PEEK: begin
            state_in = S_PEEK_CAP;
         end

         S_PEEK_CAP: begin
            res_sym_in = tape_rd;
            state_in   = S_DONE;
         end

         S_RUN_RD: begin
            state_in = S_RUN_LK;
         end

         // Tape symbol is in; rule lookup is under way
         S_RUN_LK: begin
            sym_in   = tape_rd;
            state_in = S_RUN_EX;
         end

         // Apply the rule, or stop
         S_RUN_EX: begin
            if (!rule_rd_valid || (steps_ff >= limit_ff)) begin
               res_status_in = rule_rd_valid ? tmr_pkg::STATUS_LIMIT
                                             : tmr_pkg::STATUS_NO_RULE;
               res_sym_in    = sym_ff;
               res_head_in   = cur_head_w[tmr_pkg::CELL_W-1:0];
               res_steps_in  = steps_ff;
               state_in      = S_DONE;
            end else begin
               tape_we      = 1'b1;
               tape_wd      = rule_rd.wr_sym;
               steps_in     = steps_inc;
               res_steps_in = steps_inc;
               if (unit_edge) begin
                  res_status_in = tmr_pkg::STATUS_OFF_TAPE;
                  res_sym_in    = rule_rd.wr_sym;
                  res_head_in   = cur_head_w[tmr_pkg::CELL_W-1:0];
                  state_in      = S_DONE;
               end else begin
                  cur_idx_in = unit_next;
                  if (rule_rd.halt == tmr_pkg::HALT_NONE) begin
                     mstate_in = rule_rd.next;
                     state_in  = S_RUN_RD;
                  end else begin
                     res_status_in = (rule_rd.halt == tmr_pkg::HALT_ACCEPT)
                                   ? tmr_pkg::STATUS_ACCEPTED : tmr_pkg::STATUS_REJECTED;
                     res_head_in   = next_head_w[tmr_pkg::CELL_W-1:0];
                     state_in      = S_PEEK;
                  end
               end
            end
         end

         // Hand the item to the output register once it is free
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_sym_in    = rsp_sym_ff;
      rsp_head_in   = rsp_head_ff;
      rsp_steps_in  = rsp_steps_ff;
      if ((state_ff == S_DONE) && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_sym_in    = res_sym_ff;
         rsp_head_in   = res_head_ff;
         rsp_steps_in  = res_steps_ff;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Step limit register
   assign limit_in = csr_wr_en ? csr_wr_data : limit_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         limit_ff     <= tmr_pkg::LIMIT_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         limit_ff     <= limit_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cur_idx_ff    <= cur_idx_in;
      last_idx_ff   <= last_idx_in;
      fill_sym_ff   <= fill_sym_in;
      mstate_ff     <= mstate_in;
      steps_ff      <= steps_in;
      sym_ff        <= sym_in;
      res_status_ff <= res_status_in;
      res_sym_ff    <= res_sym_in;
      res_head_ff   <= res_head_in;
      res_steps_ff  <= res_steps_in;
      rsp_status_ff <= rsp_status_in;
      rsp_sym_ff    <= rsp_sym_in;
      rsp_head_ff   <= rsp_head_in;
      rsp_steps_ff  <= rsp_steps_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.cell_symbol = rsp_sym_ff;
   assign rsp_ch.head_cell   = rsp_head_ff;
   assign rsp_ch.steps_taken = rsp_steps_ff;

   a_no_take_while_clearing : assert property (@(posedge clock) disable iff (reset)
      tape_clearing |-> !req_ch.ready)
      else $error("item taken during tape sweep");

   a_accept_leaves_idle : assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != S_IDLE))
      else $error("accepted item did not start work");

   a_done_fills_output : assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_DONE) && out_free) |=> rsp_valid_ff)
      else $error("finished item not moved to output register");

endmodule

>>> sv/tmr_tape.sv
module tmr_tape #(
   parameter int TAPE_CELLS = 1024,
   localparam int IW = $clog2(TAPE_CELLS)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_en,
   input  logic [IW-1:0]          wr_addr,
   input  tmr_pkg::sym_type       wr_data,
   input  logic [IW-1:0]          rd_addr,
   output tmr_pkg::sym_type       rd_data,
   output logic                   clearing
);

   tmr_pkg::sym_type mem [TAPE_CELLS];
   tmr_pkg::sym_type rd_data_ff;
   logic             clearing_ff;
   logic             clearing_in;
   logic [IW-1:0]    clear_idx_ff;
   logic [IW-1:0]    clear_idx_in;
   logic             mem_we;
   logic [IW-1:0]    mem_wa;
   tmr_pkg::sym_type mem_wd;

   // Sweep the tape to blank after reset, one cell a cycle
   always_comb begin
      clearing_in  = clearing_ff;
      clear_idx_in = clear_idx_ff;
      if (clearing_ff) begin
         clear_idx_in = clear_idx_ff + IW'(1);
         if (clear_idx_ff == IW'(TAPE_CELLS - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clear_idx_ff <= '0;
      end else begin
         clearing_ff  <= clearing_in;
         clear_idx_ff <= clear_idx_in;
      end
   end

   // Pick the write source: sweep first, then the sequencer
   always_comb begin
      mem_we = wr_en;
      mem_wa = wr_addr;
      mem_wd = wr_data;
      if (clearing_ff) begin
         mem_we = 1'b1;
         mem_wa = clear_idx_ff;
         mem_wd = tmr_pkg::SYM_BLANK;
      end
   end

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data  = rd_data_ff;
   assign clearing = clearing_ff;

endmodule

>>> sv/tmr_rules.sv
module tmr_rules #(
   parameter int SLOTS = 192,
   localparam int SW = $clog2(SLOTS)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  logic [SW-1:0]      wr_slot,
   input  tmr_pkg::rule_type  wr_rule,
   input  logic [SW-1:0]      rd_slot,
   output tmr_pkg::rule_type  rd_rule,
   output logic               rd_valid
);

   tmr_pkg::rule_type rule_mem [SLOTS];
   tmr_pkg::rule_type rd_rule_ff;
   logic [SLOTS-1:0]  valid_ff;
   logic [SLOTS-1:0]  valid_in;
   logic              rd_valid_ff;
   logic              wr_take;

   // First rule loaded into a slot wins; later loads are dropped
   assign wr_take = wr_en && !valid_ff[wr_slot];

   always_comb begin
      valid_in = valid_ff;
      if (wr_take) begin
         valid_in[wr_slot] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= valid_ff[rd_slot];
      end
   end

   // Rule payload store
   always_ff @(posedge clock) begin
      if (wr_take) begin
         rule_mem[wr_slot] <= wr_rule;
      end
      rd_rule_ff <= rule_mem[rd_slot];
   end

   assign rd_rule  = rd_rule_ff;
   assign rd_valid = rd_valid_ff;

   a_load_sets_valid : assert property (@(posedge clock) disable iff (reset)
      (wr_en && !valid_ff[wr_slot]) |=> valid_ff[$past(wr_slot)])
      else $error("rule slot not marked valid after load");

   a_valid_stable : assert property (@(posedge clock) disable iff (reset)
      !wr_en |=> $stable(valid_ff))
      else $error("rule valid flags changed without a load");

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam int TAPE_CELLS     = 1024;
   localparam int MACHINE_STATES = 64;
   localparam int RULE_SLOTS     = MACHINE_STATES * 3;

   // Runs longer than this are swapped for reads so one item stays bounded
   localparam int unsigned RUN_CAP = 1000;
   localparam int WATCHDOG         = 20000;
   localparam int HOLD_CYCLES      = 64;
   localparam int SETTLE_CYCLES    = 8;
   localparam int END_CYCLES       = 30;
   localparam int PHASE_ITEMS      = 190;

   // Codes the block must refuse
   localparam tmr_pkg::sym_type SYM_INVALID  = 2'd3;
   localparam logic [1:0]       HALT_INVALID = 2'd3;

   typedef struct packed {
      logic [1:0]          kind;
      tmr_pkg::cell_type   first_cell;
      tmr_pkg::cell_type   last_cell;
      tmr_pkg::sym_type    fill_symbol;
      tmr_pkg::mstate_type rule_state;
      tmr_pkg::sym_type    rule_read;
      logic [1:0]          rule_halt;
      tmr_pkg::mstate_type rule_next;
      tmr_pkg::sym_type    rule_write;
      logic                rule_move;
   } order_type;

   typedef struct packed {
      tmr_pkg::status_type status;
      tmr_pkg::sym_type    symbol;
      tmr_pkg::cell_type   head;
      tmr_pkg::step_type   steps;
   } outcome_type;

   // Machine mirror and queue of outcomes still owed by the block
   class scoreboard_type;
      tmr_pkg::sym_type  cells [TAPE_CELLS];
      bit                loaded [RULE_SLOTS];
      tmr_pkg::rule_type rules [RULE_SLOTS];
      tmr_pkg::cell_type head_pos;
      int unsigned       limit_now;
      outcome_type       owed [$];
      int                errors;

      function new();
         foreach (cells[i]) cells[i] = tmr_pkg::SYM_BLANK;
         foreach (loaded[i]) loaded[i] = 1'b0;
         foreach (rules[i]) rules[i] = '0;
         head_pos  = '0;
         limit_now = 32'(tmr_pkg::LIMIT_RESET);
         errors    = 0;
      endfunction

      function void set_limit(tmr_pkg::step_type v);
         limit_now = 32'(v);
      endfunction

      function int pending();
         return owed.size();
      endfunction

      // Step the machine from a cell; a dry pass leaves the mirror untouched
      function outcome_type run_from(tmr_pkg::cell_type start, int unsigned lim, bit dry);
         tmr_pkg::sym_type    work [TAPE_CELLS];
         int                  idx, nidx, slot;
         int unsigned         steps;
         tmr_pkg::mstate_type mstate;
         tmr_pkg::status_type st;
         bit                  going;
         tmr_pkg::rule_type   r;
         outcome_type         res;
         work   = cells;
         idx    = int'(start) + TAPE_CELLS / 2;
         mstate = '0;
         steps  = 0;
         st     = tmr_pkg::STATUS_DONE;
         going  = 1'b1;
         while (going) begin
            slot = int'(mstate) * 3 + int'(work[idx]);
            if (!loaded[slot]) begin
               st    = tmr_pkg::STATUS_NO_RULE;
               going = 1'b0;
            end else if (steps >= lim) begin
               st    = tmr_pkg::STATUS_LIMIT;
               going = 1'b0;
            end else begin
               r         = rules[slot];
               work[idx] = r.wr_sym;
               steps++;
               nidx = (r.move == tmr_pkg::MOVE_RIGHT) ? idx + 1 : idx - 1;
               if (nidx < 0 || nidx >= TAPE_CELLS) begin
                  st    = tmr_pkg::STATUS_OFF_TAPE;
                  going = 1'b0;
               end else begin
                  idx = nidx;
                  if (r.halt == tmr_pkg::HALT_ACCEPT) begin
                     st    = tmr_pkg::STATUS_ACCEPTED;
                     going = 1'b0;
                  end else if (r.halt == tmr_pkg::HALT_REJECT) begin
                     st    = tmr_pkg::STATUS_REJECTED;
                     going = 1'b0;
                  end else begin
                     mstate = r.next;
                  end
               end
            end
         end
         res.status = st;
         res.symbol = work[idx];
         res.head   = tmr_pkg::cell_type'(idx - TAPE_CELLS / 2);
         res.steps  = tmr_pkg::step_type'(steps);
         if (!dry) begin
            cells    = work;
            head_pos = res.head;
         end
         return res;
      endfunction

      // Transitions a run would take, counted no further than just past the cap
      function int unsigned run_length(tmr_pkg::cell_type start);
         outcome_type res;
         res = run_from(start, (limit_now > RUN_CAP) ? RUN_CAP + 1 : limit_now, 1'b1);
         return 32'(res.steps);
      endfunction

      // Apply one accepted item to the mirror and queue its outcome
      function void note_input(order_type o);
         outcome_type res;
         int          c, slot;
         res = '0;
         case (o.kind)
            tmr_pkg::KIND_FILL: begin
               if (o.fill_symbol == SYM_INVALID) begin
                  res.status = tmr_pkg::STATUS_BAD;
               end else if (o.last_cell >= o.first_cell) begin
                  for (c = int'(o.first_cell); c <= int'(o.last_cell); c++)
                     cells[c + TAPE_CELLS / 2] = o.fill_symbol;
               end
            end
            tmr_pkg::KIND_LOAD: begin
               if (o.rule_read == SYM_INVALID || o.rule_write == SYM_INVALID ||
                   o.rule_halt == HALT_INVALID || int'(o.rule_state) >= MACHINE_STATES ||
                   (o.rule_halt == tmr_pkg::HALT_NONE &&
                    int'(o.rule_next) >= MACHINE_STATES)) begin
                  res.status = tmr_pkg::STATUS_BAD;
               end else begin
                  slot = int'(o.rule_state) * 3 + int'(o.rule_read);
                  // first load for a slot stays
                  if (!loaded[slot]) begin
                     loaded[slot]       = 1'b1;
                     rules[slot].halt   = o.rule_halt;
                     rules[slot].next   = o.rule_next;
                     rules[slot].wr_sym = o.rule_write;
                     rules[slot].move   = o.rule_move;
                  end
               end
            end
            tmr_pkg::KIND_READ: res.symbol = cells[int'(o.first_cell) + TAPE_CELLS / 2];
            default:            res = run_from(o.first_cell, limit_now, 1'b0);
         endcase
         owed.push_back(res);
      endfunction

      task report(string what);
         errors++;
         $display("[%0t] mismatch: %s", $time, what);
      endtask

      task check(outcome_type got);
         outcome_type want;
         if (owed.size() == 0) begin
            report($sformatf("result with nothing pending (status %0d)", got.status));
            return;
         end
         want = owed.pop_front();
         if (got.status !== want.status)
            report($sformatf("status %0d, want %0d", got.status, want.status));
         if (got.symbol !== want.symbol)
            report($sformatf("cell_symbol %0d, want %0d", got.symbol, want.symbol));
         if (got.head !== want.head)
            report($sformatf("head_cell %0d, want %0d", got.head, want.head));
         if (got.steps !== want.steps)
            report($sformatf("steps_taken %0d, want %0d", got.steps, want.steps));
      endtask
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_wr_en;
   tmr_pkg::step_type csr_wr_data;
   int                hold_asks = 0;
   int                hold_done = 0;
   bit                calm_tx   = 1'b0;
   bit                calm_rx   = 1'b0;
   int                quiet;

   scoreboard_type sb = new();

   tmr_req_if req_ch ();
   tmr_rsp_if rsp_ch ();

   turing_machine_runner #(
      .TAPE_CELLS     (TAPE_CELLS),
      .MACHINE_STATES (MACHINE_STATES)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Abort when neither channel moves an item for too long
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet <= 0;
      end else begin
         quiet <= quiet + 1;
         if (quiet >= WATCHDOG) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // Result side: random stalls, one long hold-off on request
   initial begin
      outcome_type got;
      int          gap;
      rsp_ch.ready = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (hold_asks != hold_done) begin
            rsp_ch.ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done = hold_done + 1;
         end
         if ($urandom_range(0, 39) == 0) calm_rx = ~calm_rx;
         gap = calm_rx ? 0 : $urandom_range(0, 4);
         if (gap > 0) begin
            rsp_ch.ready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ch.ready = 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         got.status = rsp_ch.status;
         got.symbol = rsp_ch.cell_symbol;
         got.head   = rsp_ch.head_cell;
         got.steps  = rsp_ch.steps_taken;
         sb.check(got);
         @(negedge clock);
      end
   end

   // Offer one item after a random gap; note it once accepted
   task send_order(order_type o);
      int gap;
      if ($urandom_range(0, 39) == 0) calm_tx = ~calm_tx;
      gap = calm_tx ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.kind        = o.kind;
      req_ch.first_cell  = o.first_cell;
      req_ch.last_cell   = o.last_cell;
      req_ch.fill_symbol = o.fill_symbol;
      req_ch.rule_state  = o.rule_state;
      req_ch.rule_read   = o.rule_read;
      req_ch.rule_halt   = o.rule_halt;
      req_ch.rule_next   = o.rule_next;
      req_ch.rule_write  = o.rule_write;
      req_ch.rule_move   = o.rule_move;
      req_ch.valid       = 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_input(o);
      @(negedge clock);
   endtask

   // Drop valid and hold until every owed item has come back
   task wait_drain();
      req_ch.valid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task write_limit(tmr_pkg::step_type v);
      csr_wr_en   = 1'b1;
      csr_wr_data = v;
      @(negedge clock);
      csr_wr_en = 1'b0;
      sb.set_limit(v);
   endtask

   function order_type fill_order(int first, int last, tmr_pkg::sym_type s);
      order_type o;
      o             = '0;
      o.kind        = tmr_pkg::KIND_FILL;
      o.first_cell  = tmr_pkg::cell_type'(first);
      o.last_cell   = tmr_pkg::cell_type'(last);
      o.fill_symbol = s;
      return o;
   endfunction

   function order_type load_order(int st, tmr_pkg::sym_type rd, logic [1:0] h, int nx,
                                  tmr_pkg::sym_type wr, logic mv);
      order_type o;
      o            = '0;
      o.kind       = tmr_pkg::KIND_LOAD;
      o.rule_state = tmr_pkg::mstate_type'(st);
      o.rule_read  = rd;
      o.rule_halt  = h;
      o.rule_next  = tmr_pkg::mstate_type'(nx);
      o.rule_write = wr;
      o.rule_move  = mv;
      return o;
   endfunction

   function order_type at_cell(logic [1:0] k, int where);
      order_type o;
      o            = '0;
      o.kind       = k;
      o.first_cell = tmr_pkg::cell_type'(where);
      return o;
   endfunction

   function tmr_pkg::sym_type any_symbol();
      return tmr_pkg::sym_type'($urandom_range(0, 2));
   endfunction

   // Random item; unused fields keep random bits
   function order_type next_random();
      order_type   o;
      logic [63:0] r;
      int          pick, first, last;
      r    = {$urandom, $urandom};
      o    = r[$bits(order_type)-1:0];
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
         o.kind        = tmr_pkg::KIND_FILL;
         o.fill_symbol = ($urandom_range(0, 19) == 0) ? SYM_INVALID : any_symbol();
         first         = int'($urandom_range(0, TAPE_CELLS - 1)) - TAPE_CELLS / 2;
         pick          = $urandom_range(0, 19);
         if (pick < 17)
            last = first + int'($urandom_range(0, 27)) - 3;
         else if (pick < 19)
            last = first + int'($urandom_range(0, 200));
         else
            last = int'($urandom_range(0, TAPE_CELLS - 1)) - TAPE_CELLS / 2;
         if (last > TAPE_CELLS / 2 - 1) last = TAPE_CELLS / 2 - 1;
         o.first_cell = tmr_pkg::cell_type'(first);
         o.last_cell  = tmr_pkg::cell_type'(last);
      end else if (pick < 50) begin
         o.kind       = tmr_pkg::KIND_LOAD;
         // keep the upper states sparse so missing rules stay reachable
         o.rule_state = ($urandom_range(0, 9) < 9)
                      ? tmr_pkg::mstate_type'($urandom_range(0, 47))
                      : tmr_pkg::mstate_type'($urandom_range(48, 63));
         o.rule_read  = any_symbol();
         o.rule_write = any_symbol();
         pick         = $urandom_range(0, 99);
         o.rule_halt  = (pick < 75) ? tmr_pkg::HALT_NONE
                      : (pick < 88) ? tmr_pkg::HALT_ACCEPT : tmr_pkg::HALT_REJECT;
         pick         = $urandom_range(0, 24);
         if (pick == 0) o.rule_read = SYM_INVALID;
         if (pick == 1) o.rule_write = SYM_INVALID;
         if (pick == 2) o.rule_halt = HALT_INVALID;
      end else if (pick < 85) begin
         o.kind = tmr_pkg::KIND_RUN;
         case ($urandom_range(0, 19))
            0: o.first_cell = tmr_pkg::cell_type'(-TAPE_CELLS / 2);
            1: o.first_cell = tmr_pkg::cell_type'(TAPE_CELLS / 2 - 1);
            2: o.first_cell = tmr_pkg::cell_type'($urandom_range(0, 3) - TAPE_CELLS / 2);
            3: o.first_cell = tmr_pkg::cell_type'(TAPE_CELLS / 2 - 1
                                                  - $urandom_range(0, 3));
            default: ;
         endcase
      end else begin
         o.kind = tmr_pkg::KIND_READ;
      end
      return o;
   endfunction

   // One setting of the limit followed by a batch of random items
   task random_phase(tmr_pkg::step_type lim, int hold_at, int drain_at);
      order_type o;
      int        i;
      wait_drain();
      write_limit(lim);
      for (i = 0; i < PHASE_ITEMS; i++) begin
         if (i == hold_at) hold_asks = hold_asks + 1;
         if (i == drain_at) wait_drain();
         o = next_random();
         if (o.kind == tmr_pkg::KIND_RUN && sb.run_length(o.first_cell) > RUN_CAP)
            o.kind = tmr_pkg::KIND_READ;
         send_order(o);
      end
   endtask

   initial begin
      tmr_pkg::step_type limits [8];
      int                p;
      req_ch.valid = 1'b0;
      req_ch.kind  = tmr_pkg::KIND_FILL;
      req_ch.first_cell  = '0;
      req_ch.last_cell   = '0;
      req_ch.fill_symbol = '0;
      req_ch.rule_state  = '0;
      req_ch.rule_read   = '0;
      req_ch.rule_halt   = '0;
      req_ch.rule_next   = '0;
      req_ch.rule_write  = '0;
      req_ch.rule_move   = 1'b0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: edges of the tape, empty and refused items, every halt kind
      send_order(at_cell(tmr_pkg::KIND_READ, -512));
      send_order(at_cell(tmr_pkg::KIND_READ, 511));
      send_order(fill_order(-512, 511, tmr_pkg::SYM_ONE));
      send_order(fill_order(5, 3, tmr_pkg::SYM_ZERO));
      send_order(fill_order(0, 0, SYM_INVALID));
      send_order(fill_order(-4, 4, tmr_pkg::SYM_ZERO));
      send_order(fill_order(0, 0, tmr_pkg::SYM_BLANK));
      send_order(fill_order(99, 100, tmr_pkg::SYM_BLANK));
      send_order(fill_order(511, 511, tmr_pkg::SYM_BLANK));
      send_order(at_cell(tmr_pkg::KIND_RUN, 0));
      send_order(load_order(2, SYM_INVALID, tmr_pkg::HALT_NONE, 3, tmr_pkg::SYM_ONE,
                            tmr_pkg::MOVE_RIGHT));
      send_order(load_order(2, tmr_pkg::SYM_ZERO, tmr_pkg::HALT_NONE, 3, SYM_INVALID,
                            tmr_pkg::MOVE_RIGHT));
      send_order(load_order(2, tmr_pkg::SYM_ZERO, HALT_INVALID, 3, tmr_pkg::SYM_ONE,
                            tmr_pkg::MOVE_LEFT));
      send_order(load_order(0, tmr_pkg::SYM_BLANK, tmr_pkg::HALT_NONE, 1, tmr_pkg::SYM_ONE,
                            tmr_pkg::MOVE_RIGHT));
      send_order(load_order(0, tmr_pkg::SYM_ZERO, tmr_pkg::HALT_NONE, 0, tmr_pkg::SYM_BLANK,
                            tmr_pkg::MOVE_RIGHT));
      send_order(load_order(0, tmr_pkg::SYM_ONE, tmr_pkg::HALT_ACCEPT, 0, tmr_pkg::SYM_ZERO,
                            tmr_pkg::MOVE_LEFT));
      send_order(load_order(1, tmr_pkg::SYM_BLANK, tmr_pkg::HALT_REJECT, 0,
                            tmr_pkg::SYM_ZERO, tmr_pkg::MOVE_RIGHT));
      send_order(load_order(63, tmr_pkg::SYM_ZERO, tmr_pkg::HALT_NONE, 63, tmr_pkg::SYM_ONE,
                            tmr_pkg::MOVE_LEFT));
      send_order(load_order(0, tmr_pkg::SYM_BLANK, tmr_pkg::HALT_ACCEPT, 5,
                            tmr_pkg::SYM_ZERO, tmr_pkg::MOVE_LEFT));
      send_order(at_cell(tmr_pkg::KIND_RUN, -4));
      send_order(at_cell(tmr_pkg::KIND_RUN, 5));
      send_order(at_cell(tmr_pkg::KIND_RUN, 99));
      send_order(at_cell(tmr_pkg::KIND_RUN, 511));
      send_order(at_cell(tmr_pkg::KIND_RUN, -512));
      send_order(at_cell(tmr_pkg::KIND_READ, 4));
      send_order(at_cell(tmr_pkg::KIND_READ, -512));

      // Random phases over several limits, the largest and a limit of 1 among them
      limits = '{20'd1, 20'd1048575, 20'd3, 20'd64, 20'd300,
                 tmr_pkg::step_type'($urandom_range(1, 1000)), 20'd12, 20'd1048575};
      for (p = 0; p < 8; p++)
         random_phase(limits[p], (p == 2) ? 40 : -1, (p == 3) ? 90 : -1);

      // Let the last results come back, then allow for stragglers
      wait_drain();
      repeat (END_CYCLES) @(negedge clock);
      if (sb.pending() != 0)
         sb.report($sformatf("%0d results never arrived", sb.pending()));
      if (sb.errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
